### design/wws_pkg.sv
// ----------------------------------------------------------------------------
// wws_pkg
// Shared widths, constants, register indexes and types of the wave stencil.
// ----------------------------------------------------------------------------
package wws_pkg;

  localparam int MAX_SIDE = 33;
  localparam int MIN_SIDE = 3;
  localparam int SIDE_W   = 6;
  localparam int HW       = 24;
  localparam int DW       = 16;
  localparam int CW       = 16;

  localparam int H_DEPTH  = 2 * MAX_SIDE;
  localparam int H_AW     = $clog2(H_DEPTH);
  localparam int PD_AW    = $clog2(MAX_SIDE);
  localparam int PD_W     = HW + DW;

  localparam int SUM_W    = HW + 2;
  localparam int A_W      = CW + 1;
  localparam int B_W      = CW + 3;
  localparam int ACC_W    = 43;
  localparam int SPLIT    = 22;
  localparam int HI_W     = ACC_W - SPLIT;
  localparam int PL_W     = SPLIT + DW;
  localparam int PH_W     = HI_W + DW + 1;
  localparam int PROD_W   = 60;
  localparam int RND_SH   = 32;
  localparam int RND_W    = PROD_W - RND_SH;

  // 2.0 in Q.16; B = 2 - 4A
  localparam int B_TWO    = 131072;

  localparam int CFG_IW   = 1;
  localparam logic [CFG_IW-1:0] REG_COEF_A = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_SIDE   = CFG_IW'(1);

  localparam logic [CW-1:0]     COEF_RESET = CW'(26);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic              go;
    logic              wr;
    logic              emit;
    logic [SIDE_W-1:0] col;
    logic              wbank;
    logic              ubank;
    logic [SIDE_W-1:0] acol;
    logic              abank;
    logic              first;
    logic              at_end;
    logic              up_mem;
    logic              dn_self;
    logic              last;
  } step_t;

  typedef struct packed {
    logic signed [HW-1:0] lft;
    logic signed [HW-1:0] cen;
    logic signed [HW-1:0] rgt;
    logic signed [HW-1:0] up;
    logic signed [HW-1:0] dn;
    logic signed [HW-1:0] prv;
    logic        [DW-1:0] dmp;
  } win_t;

  function automatic logic [H_AW-1:0] h_addr(input logic bank,
                                             input logic [SIDE_W-1:0] col);
    return H_AW'(col) + (bank ? H_AW'(MAX_SIDE) : H_AW'(0));
  endfunction

endpackage

### design/wws_line.sv
// ----------------------------------------------------------------------------
// wws_line
// Line stores for two rows of heights and one row of previous height and
// damping, with the three-cell stencil window fed from the look-ahead read.
// ----------------------------------------------------------------------------
module wws_line (
  input  logic                         clk,
  input  wws_pkg::step_t               step,
  input  logic signed [wws_pkg::HW-1:0] cur_height,
  input  logic signed [wws_pkg::HW-1:0] prev_height,
  input  logic        [wws_pkg::DW-1:0] damping,
  output wws_pkg::win_t                win
);

  logic [wws_pkg::HW-1:0]   hmem  [wws_pkg::H_DEPTH];
  logic [wws_pkg::PD_W-1:0] pdmem [wws_pkg::MAX_SIDE];

  logic [wws_pkg::H_AW-1:0]  waddr;
  logic [wws_pkg::H_AW-1:0]  uaddr;
  logic [wws_pkg::H_AW-1:0]  aaddr;
  logic [wws_pkg::PD_AW-1:0] paddr;

  logic signed [wws_pkg::HW-1:0] lft;
  logic signed [wws_pkg::HW-1:0] cen;
  logic signed [wws_pkg::HW-1:0] rgt;
  logic signed [wws_pkg::HW-1:0] up;
  logic signed [wws_pkg::HW-1:0] dn;
  logic [wws_pkg::PD_W-1:0]      pd;

  assign waddr = wws_pkg::h_addr(step.wbank, step.col);
  assign uaddr = wws_pkg::h_addr(step.ubank, step.col);
  assign aaddr = wws_pkg::h_addr(step.abank, step.acol);
  assign paddr = step.col[wws_pkg::PD_AW-1:0];

  // read before write: up and pd see the old entry at the written address
  always_ff @(posedge clk) begin
    if (step.go) begin
      if (step.wr) begin
        hmem[waddr]  <= cur_height;
        pdmem[paddr] <= {prev_height, damping};
      end
      up  <= hmem[uaddr];
      rgt <= hmem[aaddr];
      pd  <= pdmem[paddr];
      cen <= rgt;
      lft <= cen;
      dn  <= cur_height;
    end
  end

  always_comb begin
    win.lft = lft;
    win.cen = cen;
    win.rgt = rgt;
    win.up  = up;
    win.dn  = dn;
    win.prv = pd[wws_pkg::PD_W-1:wws_pkg::DW];
    win.dmp = pd[wws_pkg::DW-1:0];
  end

endmodule

### design/wws_calc.sv
// ----------------------------------------------------------------------------
// wws_calc
// Stencil arithmetic as a chain of stages, each taking a beat from its
// neighbor when free: clamp and sum, coefficient products, accumulate,
// damping product in two halves, round and saturate into the result register.
// ----------------------------------------------------------------------------
module wws_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  wws_pkg::step_t                step,
  input  wws_pkg::win_t                 win,
  input  logic        [wws_pkg::CW-1:0] coef_a,
  input  logic                          res_stall,
  output logic                          s1_free,
  output logic                          res_valid,
  output logic signed [wws_pkg::HW-1:0] new_height,
  output logic                          last
);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5, r6;

  // stage 1 flags
  logic first1, end1, upm1, dself1, last1;

  // stage 2
  logic signed [wws_pkg::SUM_W-1:0] sum2;
  logic signed [wws_pkg::HW-1:0]    cen2;
  logic signed [wws_pkg::HW-1:0]    prv2;
  logic        [wws_pkg::DW-1:0]    dmp2;
  logic                             last2;

  // stage 3
  logic signed [wws_pkg::ACC_W-1:0] ma3;
  logic signed [wws_pkg::ACC_W-1:0] mb3;
  logic signed [wws_pkg::HW-1:0]    prv3;
  logic        [wws_pkg::DW-1:0]    dmp3;
  logic                             last3;

  // stage 4
  logic signed [wws_pkg::ACC_W-1:0] acc4;
  logic        [wws_pkg::DW-1:0]    dmp4;
  logic                             last4;

  // stage 5
  logic        [wws_pkg::PL_W-1:0]  plo5;
  logic signed [wws_pkg::PH_W-1:0]  phi5;
  logic                             last5;

  logic signed [wws_pkg::B_W-1:0]   coef_b;
  logic signed [wws_pkg::A_W-1:0]   coef_as;
  logic signed [wws_pkg::HW-1:0]    tap_l, tap_r, tap_u, tap_d;
  logic signed [wws_pkg::SUM_W-1:0] sum1;
  logic signed [wws_pkg::HW+wws_pkg::DW-1:0] prv_sh;
  logic signed [wws_pkg::PROD_W-1:0] prod;
  logic signed [wws_pkg::PROD_W-1:0] rnd;
  logic signed [wws_pkg::RND_W-1:0]  rq;
  logic signed [wws_pkg::HW-1:0]     sat;
  logic                              ovf;

  assign coef_as = $signed({1'b0, coef_a});
  assign coef_b  = $signed(wws_pkg::B_W'(wws_pkg::B_TWO) - wws_pkg::B_W'({coef_a, 2'b00}));

  assign r6 = !res_valid || !res_stall;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s1_free = r1;

  always_comb begin
    tap_l = first1 ? win.cen : win.lft;
    tap_r = end1   ? win.cen : win.rgt;
    tap_u = upm1   ? win.up  : win.cen;
    tap_d = dself1 ? win.cen : win.dn;
    sum1  = wws_pkg::SUM_W'(tap_l) + wws_pkg::SUM_W'(tap_r)
          + wws_pkg::SUM_W'(tap_u) + wws_pkg::SUM_W'(tap_d);
  end

  assign prv_sh = {prv3, wws_pkg::DW'(0)};

  always_comb begin
    prod = (wws_pkg::PROD_W'(phi5) <<< wws_pkg::SPLIT)
         + $signed(wws_pkg::PROD_W'(plo5));
    rnd  = prod + (wws_pkg::PROD_W'(1) <<< (wws_pkg::RND_SH - 1));
    rq   = rnd[wws_pkg::PROD_W-1:wws_pkg::RND_SH];
    ovf  = (rq[wws_pkg::RND_W-1:wws_pkg::HW-1] != '0)
        && (rq[wws_pkg::RND_W-1:wws_pkg::HW-1] != '1);
    if (!ovf) begin
      sat = rq[wws_pkg::HW-1:0];
    end else if (rq[wws_pkg::RND_W-1]) begin
      sat = {1'b1, {(wws_pkg::HW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(wws_pkg::HW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= step.go && step.emit;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        v4 <= v3;
      end
      if (r5) begin
        v5 <= v4;
      end
      if (r6) begin
        res_valid <= v5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      first1 <= step.first;
      end1   <= step.at_end;
      upm1   <= step.up_mem;
      dself1 <= step.dn_self;
      last1  <= step.last;
    end
    if (r2) begin
      sum2  <= sum1;
      cen2  <= win.cen;
      prv2  <= win.prv;
      dmp2  <= win.dmp;
      last2 <= last1;
    end
    if (r3) begin
      ma3   <= coef_as * sum2;
      mb3   <= coef_b * cen2;
      prv3  <= prv2;
      dmp3  <= dmp2;
      last3 <= last2;
    end
    if (r4) begin
      acc4  <= ma3 + mb3 - wws_pkg::ACC_W'(prv_sh);
      dmp4  <= dmp3;
      last4 <= last3;
    end
    if (r5) begin
      plo5  <= wws_pkg::PL_W'(acc4[wws_pkg::SPLIT-1:0]) * wws_pkg::PL_W'(dmp4);
      phi5  <= $signed(acc4[wws_pkg::ACC_W-1:wws_pkg::SPLIT]) * $signed({1'b0, dmp4});
      last5 <= last4;
    end
    if (r6) begin
      new_height <= sat;
      last       <= last5;
    end
  end

endmodule

### design/wws_ctrl.sv
// ----------------------------------------------------------------------------
// wws_ctrl
// Raster position counters and the end-of-grid flush sequencer; issues one
// step per node or per flushed column to the line stores and the stage chain.
// ----------------------------------------------------------------------------
module wws_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [wws_pkg::SIDE_W-1:0]      nodes_per_side,
  input  logic                            node_valid,
  input  logic                            s1_free,
  output logic                            node_stall,
  output wws_pkg::step_t                  step
);

  wws_pkg::ctrl_state_t state, state_next;

  logic [wws_pkg::SIDE_W-1:0] col, col_next;
  logic [wws_pkg::SIDE_W-1:0] row, row_next;
  logic [wws_pkg::SIDE_W-1:0] fcol, fcol_next;
  logic                       fbank, fbank_next;

  logic [wws_pkg::SIDE_W-1:0] side;
  logic [wws_pkg::SIDE_W-1:0] side_m1;
  logic                       wrap;
  logic [wws_pkg::SIDE_W-1:0] c;
  logic [wws_pkg::SIDE_W-1:0] r;
  logic                       c_last, r_last, f_last;
  logic                       accept;

  always_comb begin
    if (nodes_per_side < wws_pkg::SIDE_W'(wws_pkg::MIN_SIDE)) begin
      side = wws_pkg::SIDE_W'(wws_pkg::MIN_SIDE);
    end else if (nodes_per_side > wws_pkg::SIDE_W'(wws_pkg::MAX_SIDE)) begin
      side = wws_pkg::SIDE_W'(wws_pkg::MAX_SIDE);
    end else begin
      side = nodes_per_side;
    end
  end

  assign side_m1 = side - wws_pkg::SIDE_W'(1);
  assign wrap    = (col >= side) || (row >= side);
  assign c       = wrap ? wws_pkg::SIDE_W'(0) : col;
  assign r       = wrap ? wws_pkg::SIDE_W'(0) : row;
  assign c_last  = (c == side_m1);
  assign r_last  = (r == side_m1);
  assign f_last  = (fcol == side_m1);
  assign accept  = (state == wws_pkg::ST_RUN) && node_valid && s1_free;

  always_comb begin
    step       = '0;
    node_stall = 1'b1;
    unique case (state)
      wws_pkg::ST_RUN: begin
        node_stall   = !s1_free;
        step.go      = accept;
        step.wr      = 1'b1;
        step.emit    = (r != wws_pkg::SIDE_W'(0));
        step.col     = c;
        step.wbank   = r[0];
        step.ubank   = r[0];
        step.first   = (c == wws_pkg::SIDE_W'(0));
        step.at_end  = c_last;
        step.up_mem  = (r > wws_pkg::SIDE_W'(1));
        step.dn_self = 1'b0;
        step.last    = 1'b0;
        if (c_last) begin
          step.acol  = wws_pkg::SIDE_W'(0);
          step.abank = r[0];
        end else begin
          step.acol  = c + wws_pkg::SIDE_W'(1);
          step.abank = !r[0];
        end
      end
      wws_pkg::ST_FLUSH: begin
        node_stall   = 1'b1;
        step.go      = s1_free;
        step.wr      = 1'b0;
        step.emit    = 1'b1;
        step.col     = fcol;
        step.wbank   = fbank;
        step.ubank   = !fbank;
        step.first   = (fcol == wws_pkg::SIDE_W'(0));
        step.at_end  = f_last;
        step.up_mem  = 1'b1;
        step.dn_self = 1'b1;
        step.last    = f_last;
        step.acol    = f_last ? wws_pkg::SIDE_W'(0) : fcol + wws_pkg::SIDE_W'(1);
        step.abank   = fbank;
      end
      default: begin
        step       = '0;
        node_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    fcol_next  = fcol;
    fbank_next = fbank;
    unique case (state)
      wws_pkg::ST_RUN: begin
        if (accept) begin
          if (c_last && r_last) begin
            col_next   = wws_pkg::SIDE_W'(0);
            row_next   = wws_pkg::SIDE_W'(0);
            fcol_next  = wws_pkg::SIDE_W'(0);
            fbank_next = r[0];
            state_next = wws_pkg::ST_FLUSH;
          end else if (c_last) begin
            col_next = wws_pkg::SIDE_W'(0);
            row_next = r + wws_pkg::SIDE_W'(1);
          end else begin
            col_next = c + wws_pkg::SIDE_W'(1);
            row_next = r;
          end
        end
      end
      wws_pkg::ST_FLUSH: begin
        if (s1_free) begin
          fcol_next = fcol + wws_pkg::SIDE_W'(1);
          if (f_last) begin
            state_next = wws_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_next = wws_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wws_pkg::ST_RUN;
      col   <= '0;
      row   <= '0;
      fcol  <= '0;
      fbank <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      fcol  <= fcol_next;
      fbank <= fbank_next;
    end
  end

endmodule

### design/water_wave_stencil_step.sv
// ----------------------------------------------------------------------------
// water_wave_stencil_step
// Damped 2-D wave update over a square height grid streamed in raster order.
// Takes one node beat per cycle while the result side keeps up; each node of
// row r > 0 yields the result for node (r-1, c) through a six-stage arithmetic
// chain behind a look-ahead read of the line store. The final node of the grid
// is followed by a flush, one step per column of the last row, during which
// node_stall stays high; one write and two read ports of the line store set
// the one-node-per-cycle figure. The user must write coef_a and nodes_per_side
// via the cfg port only while no result is pending; the block doesn't check.
// ----------------------------------------------------------------------------
module water_wave_stencil_step (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_write,
  input  logic [wws_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [wws_pkg::CW-1:0]              cfg_data,

  input  logic                                node_valid,
  output logic                                node_stall,
  input  logic signed [wws_pkg::HW-1:0]       cur_height,
  input  logic signed [wws_pkg::HW-1:0]       prev_height,
  input  logic        [wws_pkg::DW-1:0]       damping,

  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [wws_pkg::HW-1:0]       new_height,
  output logic                                last
);

  logic [wws_pkg::CW-1:0]     coef_a;
  logic [wws_pkg::SIDE_W-1:0] nodes_per_side;

  wws_pkg::step_t step;
  wws_pkg::win_t  win;
  logic           s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a         <= wws_pkg::COEF_RESET;
      nodes_per_side <= wws_pkg::SIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wws_pkg::REG_COEF_A: coef_a         <= cfg_data;
        wws_pkg::REG_SIDE:   nodes_per_side <= cfg_data[wws_pkg::SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wws_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .nodes_per_side (nodes_per_side),
    .node_valid     (node_valid),
    .s1_free        (s1_free),
    .node_stall     (node_stall),
    .step           (step)
  );

  wws_line u_line (
    .clk         (clk),
    .step        (step),
    .cur_height  (cur_height),
    .prev_height (prev_height),
    .damping     (damping),
    .win         (win)
  );

  wws_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .win        (win),
    .coef_a     (coef_a),
    .res_stall  (res_stall),
    .s1_free    (s1_free),
    .res_valid  (res_valid),
    .new_height (new_height),
    .last       (last)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the damped wave stencil. Node beats carry
// random heights and damping factors in whole and partial raster grids
// across several coefficient and side settings, the extremes included.
// A bit-accurate predictor of the stencil and the row flush queues the
// expected heights, and each result beat is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  CLK_HALF     = 6;
  localparam int  SETTLE_CYC   = 16;
  localparam int  RANDOM_NODES = 285;
  localparam int  TIMEOUT_NS   = 3_000_000;

  localparam logic signed [wws_pkg::HW-1:0] H_TOP = 24'sh7FFFFF;
  localparam logic signed [wws_pkg::HW-1:0] H_BOT = 24'sh800000;
  localparam longint SAT_HI = 8388607;
  localparam longint SAT_LO = -8388608;

  typedef struct {
    logic signed [wws_pkg::HW-1:0] height;
    logic                          last;
  } height_beat_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [wws_pkg::CFG_IW-1:0]     cfg_index;
  logic [wws_pkg::CW-1:0]         cfg_data;
  logic                           node_valid;
  logic                           node_stall;
  logic signed [wws_pkg::HW-1:0]  cur_height;
  logic signed [wws_pkg::HW-1:0]  prev_height;
  logic [wws_pkg::DW-1:0]         damping;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  logic signed [wws_pkg::HW-1:0]  new_height;
  logic                           last;

  // predictor state
  longint                 height_rows [0:2*wws_pkg::MAX_SIDE-1];
  longint                 prev_row    [0:wws_pkg::MAX_SIDE-1];
  logic [wws_pkg::DW-1:0] damp_row    [0:wws_pkg::MAX_SIDE-1];
  int                     col_pos;
  int                     row_pos;
  logic [wws_pkg::CW-1:0] coef_q;
  logic [5:0]             side_q;

  height_beat_t  pending_heights[$];
  height_beat_t  head_beat;
  int            errors;
  int            beats_seen;
  int            gap_pct;
  int            stall_pct;

  water_wave_stencil_step u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .node_valid  (node_valid),
    .node_stall  (node_stall),
    .cur_height  (cur_height),
    .prev_height (prev_height),
    .damping     (damping),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .new_height  (new_height),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** water_wave_stencil_step: FAILED **");
    $finish;
  end

  function automatic int side_eff(input logic [5:0] s);
    if (s < wws_pkg::MIN_SIDE) return wws_pkg::MIN_SIDE;
    if (s > wws_pkg::MAX_SIDE) return wws_pkg::MAX_SIDE;
    return int'(s);
  endfunction

  function automatic logic signed [wws_pkg::HW-1:0] damped_height(input int bank,
      input int c, input int n, input longint up, input longint dn, input longint prv,
      input logic [wws_pkg::DW-1:0] dmp);
    longint centre, lft, rgt, a, b, acc, prod, res;
    centre = height_rows[bank*wws_pkg::MAX_SIDE + c];
    lft    = (c > 0) ? height_rows[bank*wws_pkg::MAX_SIDE + c - 1] : centre;
    rgt    = (c + 1 < n) ? height_rows[bank*wws_pkg::MAX_SIDE + c + 1] : centre;
    a      = longint'(coef_q);
    b      = longint'(wws_pkg::B_TWO) - 4 * a;
    acc    = a * (lft + rgt + up + dn) + b * centre - prv * 65536;
    prod   = acc * longint'(dmp);
    // round half up from Q.32 to the height scale, then saturate
    res    = (prod + 64'sd2147483648) >>> 32;
    if (res > SAT_HI) res = SAT_HI;
    if (res < SAT_LO) res = SAT_LO;
    return wws_pkg::HW'(res);
  endfunction

  function automatic void predict_node(input logic signed [wws_pkg::HW-1:0] cur,
      input logic signed [wws_pkg::HW-1:0] prv, input logic [wws_pkg::DW-1:0] dmp);
    int n, c, r, here, above, k;
    longint up;
    height_beat_t beat;
    n = side_eff(side_q);
    if (col_pos >= n || row_pos >= n) begin
      col_pos = 0;
      row_pos = 0;
    end
    c     = col_pos;
    r     = row_pos;
    here  = r & 1;
    above = (r + 1) & 1;
    if (r > 0) begin
      up = (r >= 2) ? height_rows[here*wws_pkg::MAX_SIDE + c]
                    : height_rows[above*wws_pkg::MAX_SIDE + c];
      beat.height = damped_height(above, c, n, up, longint'(cur), prev_row[c], damp_row[c]);
      beat.last   = 1'b0;
      pending_heights.push_back(beat);
    end
    height_rows[here*wws_pkg::MAX_SIDE + c] = cur;
    prev_row[c] = prv;
    damp_row[c] = dmp;
    if (c + 1 == n && r + 1 == n) begin
      // flush the last row against itself
      for (k = 0; k < n; k++) begin
        beat.height = damped_height(here, k, n, height_rows[above*wws_pkg::MAX_SIDE + k],
                                    height_rows[here*wws_pkg::MAX_SIDE + k],
                                    prev_row[k], damp_row[k]);
        beat.last   = (k + 1 == n);
        pending_heights.push_back(beat);
      end
      col_pos = 0;
      row_pos = 0;
    end else begin
      c++;
      if (c == n) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
  endfunction

  function automatic int nodes_left(input int n);
    if (col_pos >= n || row_pos >= n) return n * n;
    return n * n - (row_pos * n + col_pos);
  endfunction

  function automatic logic signed [wws_pkg::HW-1:0] pick_height();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return wws_pkg::HW'($urandom);
    if (sel < 85) return wws_pkg::HW'(int'($urandom_range(4095)) - 2048);
    case ($urandom_range(3))
      0: return H_TOP;
      1: return H_BOT;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [wws_pkg::DW-1:0] pick_damping();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return wws_pkg::DW'($urandom);
    if (sel < 88) return '1;
    return '0;
  endfunction

  function automatic logic [wws_pkg::CW-1:0] pick_coef();
    case ($urandom_range(4))
      0: return '0;
      1: return wws_pkg::CW'(32768);
      2: return wws_pkg::CW'(26);
      3: return wws_pkg::CW'($urandom_range(32768));
      default: return wws_pkg::CW'($urandom_range(200));
    endcase
  endfunction

  function automatic logic [wws_pkg::CW-1:0] pick_side();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) return wws_pkg::CW'($urandom_range(3, 8));
    if (sel < 82) return wws_pkg::CW'($urandom_range(9, 20));
    if (sel < 89) return wws_pkg::CW'(wws_pkg::MAX_SIDE);
    if (sel < 94) return wws_pkg::CW'(63);
    return wws_pkg::CW'($urandom_range(2));
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("beat %0d: %s", beats_seen, msg);
  endtask

  // hold valid and payload until the beat is taken
  task automatic send_node(input logic signed [wws_pkg::HW-1:0] cur,
      input logic signed [wws_pkg::HW-1:0] prv, input logic [wws_pkg::DW-1:0] dmp);
    while ($urandom_range(99) < gap_pct) begin
      node_valid <= 1'b0;
      @(posedge clk);
    end
    node_valid  <= 1'b1;
    cur_height  <= cur;
    prev_height <= prv;
    damping     <= dmp;
    do @(posedge clk); while (node_stall);
    predict_node(cur, prv, dmp);
  endtask

  task automatic settle();
    node_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic configure(input logic [wws_pkg::CW-1:0] a,
      input logic [wws_pkg::CW-1:0] side);
    cfg_write <= 1'b1;
    cfg_index <= wws_pkg::REG_COEF_A;
    cfg_data  <= a;
    @(posedge clk);
    coef_q = a;
    cfg_index <= wws_pkg::REG_SIDE;
    cfg_data  <= side;
    @(posedge clk);
    side_q = side[5:0];
    cfg_write <= 1'b0;
  endtask

  // full-scale heights against the largest coefficient, side below minimum
  task automatic test_saturation_corners();
    int k;
    settle();
    configure(wws_pkg::CW'(32768), wws_pkg::CW'(2));
    for (k = 0; k < 9; k++)
      send_node((k % 2) ? H_BOT : H_TOP, (k % 3 == 0) ? H_BOT : H_TOP,
                (k == 4) ? wws_pkg::DW'(0) : wws_pkg::DW'(16'hFFFF));
    settle();
  endtask

  // shrink the side mid-grid so the next node restarts a grid
  task automatic test_side_shrink();
    int k;
    settle();
    configure(wws_pkg::CW'(0), wws_pkg::CW'(4));
    for (k = 0; k < 7; k++) send_node(pick_height(), pick_height(), pick_damping());
    settle();
    configure(pick_coef(), wws_pkg::CW'(0));
    for (k = 0; k < 9; k++) send_node(pick_height(), pick_height(), pick_damping());
    settle();
  endtask

  task automatic test_random_grids();
    int sent, phase, n, cnt, k, cur_n;
    logic [wws_pkg::CW-1:0] side;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_NODES) begin
      gap_pct   = (phase >= 4 && phase <= 7) ? 0 : 10;
      stall_pct = gap_pct;
      settle();
      cur_n = side_eff(side_q);
      side  = pick_side();
      // never grow the side under rows already started
      if (row_pos > 0 && row_pos < cur_n && col_pos < cur_n &&
          side_eff(side[5:0]) > cur_n)
        side = wws_pkg::CW'($urandom_range(cur_n));
      configure(pick_coef(), side);
      n   = side_eff(side_q);
      cnt = nodes_left(n);
      if (n > 20) begin
        k = $urandom_range(2 * n, 80);
        if (k < cnt) cnt = k;
      end else if ($urandom_range(99) < 20 && cnt > 1) begin
        cnt = $urandom_range(1, cnt - 1);
      end
      if (cnt > RANDOM_NODES - sent) cnt = RANDOM_NODES - sent;
      for (k = 0; k < cnt; k++) send_node(pick_height(), pick_height(), pick_damping());
      sent += cnt;
      phase++;
    end
    gap_pct   = 10;
    stall_pct = 10;
    settle();
  endtask

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      beats_seen++;
      if (pending_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected result height %0d last %0b",
                                  new_height, last));
      end else begin
        head_beat = pending_heights.pop_front();
        if (new_height !== head_beat.height)
          report_mismatch($sformatf("height %0d, want %0d", new_height, head_beat.height));
        if (last !== head_beat.last)
          report_mismatch($sformatf("last %0b, want %0b", last, head_beat.last));
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= wws_pkg::REG_COEF_A;
    cfg_data    <= '0;
    node_valid  <= 1'b0;
    cur_height  <= '0;
    prev_height <= '0;
    damping     <= '0;
    errors      = 0;
    beats_seen  = 0;
    gap_pct     = 10;
    stall_pct   = 10;
    coef_q      = wws_pkg::COEF_RESET;
    side_q      = wws_pkg::SIDE_RESET;
    col_pos     = 0;
    row_pos     = 0;
    foreach (height_rows[i]) height_rows[i] = 0;
    foreach (prev_row[i]) prev_row[i] = 0;
    foreach (damp_row[i]) damp_row[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_saturation_corners();
    test_side_shrink();
    test_random_grids();

    settle();
    if (errors == 0) begin
      $display("** water_wave_stencil_step: PASSED **");
    end else begin
      $display("** water_wave_stencil_step: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
design/wws_pkg.sv
design/wws_line.sv
design/wws_calc.sv
design/wws_ctrl.sv
design/water_wave_stencil_step.sv
bench/tb_top.sv
